// ----- rtl/core/aes128_block_encrypt_macros.svh -----
// assertion macros for the aes128 block encryption checker
// no dependencies
`ifndef AES128_BLOCK_ENCRYPT_MACROS_SVH
`define AES128_BLOCK_ENCRYPT_MACROS_SVH

// property that must hold on every clock edge outside reset
`define AES_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked at every clock edge, including reset
`define AES_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/core/aes_pkg.sv -----
// shared types, constants and round functions for the aes-128 pipeline
// no dependencies
package aes_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned BlockW    = 128;
  localparam int unsigned HalfW     = 64;

  typedef logic [BlockW-1:0] block_t;
  typedef logic [7:0]        byte_t;

  // configuration register indexes
  typedef enum logic {
    CFG_KEY_HIGH = 1'b0,
    CFG_KEY_LOW  = 1'b1
  } cfg_idx_e;

  // forward substitution box
  function automatic byte_t sbox(input byte_t a);
    byte_t r;
    case (a)
      8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
      8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
      8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
      8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
      8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
      8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
      8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
      8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
      8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
      8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
      8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
      8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
      8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
      8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
      8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
      8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
      8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
      8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
      8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
      8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
      8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
      8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
      8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
      8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
      8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
      8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
      8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
      8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
      8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
      8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
      8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
      8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
      8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
      8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
      8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
      8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
      8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
      8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
      8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
      8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
      8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
      8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
      8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
      8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
      8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
      8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
      8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
      8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
      8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
      8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
      8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
      8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
      8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
      8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
      8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
      8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
      8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
      8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
      8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
      8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
      8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
      8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
      8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
      8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
      default: r=8'h00;
    endcase
    return r;
  endfunction

  function automatic byte_t xtime(input byte_t a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of a block, byte 0 in the top bits
  function automatic byte_t get_b(input block_t s, input int unsigned i);
    return s[BlockW-1-8*i -: 8];
  endfunction

  // subbytes and shiftrows
  function automatic block_t sub_shift(input block_t s);
    block_t t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[BlockW-1-8*(r+4*c) -: 8] = sbox(get_b(s, r + 4*((c + r) % 4)));
      end
    end
    return t;
  endfunction

  function automatic block_t mix_columns(input block_t s);
    block_t t;
    byte_t  a0, a1, a2, a3, al;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = get_b(s, 4*c);
      a1 = get_b(s, 4*c+1);
      a2 = get_b(s, 4*c+2);
      a3 = get_b(s, 4*c+3);
      al = a0 ^ a1 ^ a2 ^ a3;
      t[BlockW-1-32*c -: 32] = {a0 ^ al ^ xtime(a0 ^ a1), a1 ^ al ^ xtime(a1 ^ a2),
                                a2 ^ al ^ xtime(a2 ^ a3), a3 ^ al ^ xtime(a3 ^ a0)};
    end
    return t;
  endfunction

  // next round key from previous round key and round constant
  function automatic block_t next_key(input block_t k, input byte_t rcon);
    logic [31:0] w0, w1, w2, w3, tw;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    tw = {sbox(w3[23:16]) ^ rcon, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
    w0 = w0 ^ tw;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  // round constant for round r, counted from 1
  function automatic byte_t rcon_of(input int unsigned r);
    byte_t v;
    v = 8'h01;
    for (int i = 1; i < NumRounds; i++) begin
      if (i < r) v = xtime(v);
    end
    return v;
  endfunction

endpackage

// ----- rtl/core/aes128_block_encrypt.sv -----
// aes-128 encryption, one round per pipeline stage, round keys expanded alongside
// depends on aes_pkg
//
//  channel  | handshake        | payload
//  ---------+------------------+-------------------------------------
//  config   | cfg_we_i         | cfg_idx_i, cfg_wdata_i (64 bits)
//  input    | start_i & !busy_o| plaintext_high_i, plaintext_low_i
//  output   | done_o strobe    | ciphertext_high_o, ciphertext_low_o
//
// one item per cycle; each item passes the key add stage, then one stage per
// round, in the unrolled round stages
// busy_o is always low: the pipeline never stalls and results cannot be held off
// each item carries its own round key down the pipeline, so a key write affects
// items accepted after it
// reset clears the key registers and the valid bits of every stage
module aes128_block_encrypt
  import aes_pkg::*;
#(
  parameter int unsigned NUM_ROUNDS = NumRounds
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [HalfW-1:0]  cfg_wdata_i,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [HalfW-1:0]  plaintext_high_i,
  input  logic [HalfW-1:0]  plaintext_low_i,
  output logic              done_o,
  output logic [HalfW-1:0]  ciphertext_high_o,
  output logic [HalfW-1:0]  ciphertext_low_o
);

  logic [HalfW-1:0] key_high_q, key_low_q;

  // stage 0 holds the state after the initial key add
  logic   [NUM_ROUNDS:0] valid_q;
  block_t                state_q [NUM_ROUNDS+1];
  block_t                rkey_q  [NUM_ROUNDS+1];

  // key registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_KEY_HIGH: key_high_q <= cfg_wdata_i;
        CFG_KEY_LOW:  key_low_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[NUM_ROUNDS-1:0], start_i};
    end
  end

  // initial key add
  always_ff @(posedge clk_i) begin
    state_q[0] <= {plaintext_high_i, plaintext_low_i} ^ {key_high_q, key_low_q};
    rkey_q[0]  <= {key_high_q, key_low_q};
  end

  // round stages
  for (genvar r = 1; r <= NUM_ROUNDS; r++) begin : g_round
    block_t key_d, st_d;
    always_comb begin
      key_d = next_key(rkey_q[r-1], rcon_of(r));
      if (r == NUM_ROUNDS) st_d = sub_shift(state_q[r-1]) ^ key_d;
      else                 st_d = mix_columns(sub_shift(state_q[r-1])) ^ key_d;
    end
    always_ff @(posedge clk_i) begin
      if (valid_q[r-1]) begin
        state_q[r] <= st_d;
        rkey_q[r]  <= key_d;
      end
    end
  end

  assign done_o            = valid_q[NUM_ROUNDS];
  assign ciphertext_high_o = state_q[NUM_ROUNDS][BlockW-1:HalfW];
  assign ciphertext_low_o  = state_q[NUM_ROUNDS][HalfW-1:0];

endmodule

// ----- rtl/core/aes_checker.sv -----
// port-level checker for aes128_block_encrypt, bound into every instance of that module
// depends on aes_pkg and aes128_block_encrypt_macros.svh
`include "aes128_block_encrypt_macros.svh"
module aes_checker
  import aes_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic done_o
);

  // cycles from an accepted item to its result strobe
  localparam int unsigned Lat = NumRounds + 1;

  // the pipeline never refuses an item
  `AES_ASSERT(a_never_busy, clk_i, rst_ni, !busy_o, "busy raised")
  // each item gives its result after the fixed latency
  `AES_ASSERT(a_latency, clk_i, rst_ni, (start_i && !busy_o) |-> ##Lat done_o, "result missing")
  // no result without an item accepted earlier
  `AES_ASSERT(a_no_spurious, clk_i, rst_ni, done_o |-> $past(start_i, Lat), "spurious result")
  // no result right out of reset
  `AES_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |=> !done_o, "result after reset")

endmodule

bind aes128_block_encrypt aes_checker u_aes_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .done_o  (done_o)
);

// ----- dv/aes128_block_encrypt_test.sv -----
// self-checking testbench for the aes-128 block encryption pipeline
// depends on aes_pkg and aes128_block_encrypt; predicts ciphertext with its own cipher
`timescale 1ns / 100ps

module aes128_block_encrypt_test;
  import aes_pkg::*;

  localparam int unsigned PipeDepth = NumRounds + 1;
  localparam int unsigned IdleLimit = 2000;

  typedef logic [63:0] half_t;
  typedef logic [127:0] blk_t;

  // forward s-box contents, byte order as in FIPS-197
  localparam logic [2047:0] SboxTab = {
    128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16};

  function automatic logic [7:0] subst(logic [7:0] a);
    return SboxTab[2047 - 8*a -: 8];
  endfunction

  function automatic logic [7:0] dbl(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // full aes-128 encryption of one block under one key
  function automatic blk_t encrypt_block(blk_t key, blk_t pt);
    logic [7:0] st [16];
    logic [7:0] tmp [16];
    logic [7:0] rk [176];
    logic [7:0] tw [4];
    logic [7:0] rc, x, a0, a1, a2, a3, al;
    blk_t res;
    rc = 8'h01;
    for (int i = 0; i < 16; i++) begin
      rk[i] = key[127-8*i -: 8];
      st[i] = pt[127-8*i -: 8] ^ rk[i];
    end
    for (int i = 4; i < 44; i++) begin
      for (int j = 0; j < 4; j++) tw[j] = rk[4*(i-1)+j];
      if (i % 4 == 0) begin
        x = tw[0];
        tw[0] = subst(tw[1]) ^ rc;
        tw[1] = subst(tw[2]);
        tw[2] = subst(tw[3]);
        tw[3] = subst(x);
        rc = dbl(rc);
      end
      for (int j = 0; j < 4; j++) rk[4*i+j] = rk[4*(i-4)+j] ^ tw[j];
    end
    for (int r = 1; r <= 10; r++) begin
      for (int c = 0; c < 4; c++)
        for (int w = 0; w < 4; w++) tmp[w+4*c] = subst(st[w+4*((c+w)%4)]);
      st = tmp;
      if (r < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
          al = a0 ^ a1 ^ a2 ^ a3;
          st[4*c]   = a0 ^ al ^ dbl(a0 ^ a1);
          st[4*c+1] = a1 ^ al ^ dbl(a1 ^ a2);
          st[4*c+2] = a2 ^ al ^ dbl(a2 ^ a3);
          st[4*c+3] = a3 ^ al ^ dbl(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) st[i] ^= rk[16*r+i];
    end
    for (int i = 0; i < 16; i++) res[127-8*i -: 8] = st[i];
    return res;
  endfunction

  // expected ciphertext queue and comparison
  class cipher_scoreboard;
    blk_t pending_ct[$];
    int   errors;
    int   matched;

    function void note_block(blk_t key, half_t hi, half_t lo);
      pending_ct.push_back(encrypt_block(key, {hi, lo}));
    endfunction

    function void check_block(half_t hi, half_t lo);
      blk_t exp_ct;
      if (pending_ct.size() == 0) begin
        errors++;
        $display("%0t: unexpected ciphertext %h_%h", $time, hi, lo);
        return;
      end
      exp_ct = pending_ct.pop_front();
      if (exp_ct[127:64] !== hi) begin
        errors++;
        $display("%0t: ciphertext_high expected %h actual %h", $time, exp_ct[127:64], hi);
      end
      if (exp_ct[63:0] !== lo) begin
        errors++;
        $display("%0t: ciphertext_low expected %h actual %h", $time, exp_ct[63:0], lo);
      end
      matched++;
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = 1'b0;
  logic [63:0] cfg_wdata_i = '0;
  logic start_i = 1'b0;
  logic busy_o;
  half_t plaintext_high_i = '0;
  half_t plaintext_low_i = '0;
  logic done_o;
  half_t ciphertext_high_o, ciphertext_low_o;

  cipher_scoreboard sb = new();
  blk_t cur_key = '0;
  int   gap_pct = 0;
  int   idle_cycles = 0;
  int   n_items = 0;
  int   n_keys = 0;

  always #5 clk_i = ~clk_i;

  aes128_block_encrypt dut (.*);

  // result capture and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) sb.check_block(ciphertext_high_o, ciphertext_low_o);
      if (done_o || (start_i && !busy_o)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IdleLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic write_key_reg(cfg_idx_e idx, half_t val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CFG_KEY_HIGH) cur_key[127:64] = val;
    else cur_key[63:0] = val;
  endtask

  // wait for the pipeline to drain before touching the key; called at a falling edge
  task automatic drain;
    start_i = 1'b0;
    while (sb.pending_ct.size() != 0) @(negedge clk_i);
    repeat (PipeDepth + 2) @(negedge clk_i);
  endtask

  task automatic load_key(half_t hi, half_t lo);
    drain();
    write_key_reg(CFG_KEY_HIGH, hi);
    write_key_reg(CFG_KEY_LOW, lo);
    n_keys++;
  endtask

  // present one item, for gap_pct percent of items with a random gap before it; start stays high across items
  task automatic send_block(half_t hi, half_t lo);
    if ($urandom_range(99) < gap_pct) begin
      start_i = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    start_i = 1'b1;
    plaintext_high_i = hi;
    plaintext_low_i = lo;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sb.note_block(cur_key, hi, lo);
    n_items++;
    @(negedge clk_i);
  endtask

  function automatic half_t rand_half();
    half_t v;
    case ($urandom_range(5))
      0: v = '0;
      1: v = '1;
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset key, FIPS-197 vector, extremes
    send_block(64'h0, 64'h0);
    load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
    send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
    load_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c);
    send_block(64'h3243f6a8885a308d, 64'h313198a2e0370734);
    send_block(64'hffffffffffffffff, 64'hffffffffffffffff);
    load_key('1, '1);
    send_block('0, '0);
    send_block('1, '1);
    send_block(64'h8000000000000000, 64'h1);
    load_key('0, '1);
    send_block(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
    load_key('0, '0);
    send_block('1, '0);

    // random: three idle profiles, new key every so often
    for (int ph = 0; ph < 3; ph++) begin
      gap_pct = (ph == 0) ? 10 : (ph == 1) ? 53 : 0;
      for (int k = 0; k < 8; k++) begin
        load_key(rand_half(), rand_half());
        for (int i = 0; i < 83; i++) send_block(rand_half(), rand_half());
        if (k == 4) drain();
      end
    end

    drain();
    repeat (PipeDepth * 4) @(negedge clk_i);
    $display("covered %0d blocks under %0d keys, %0d results checked",
             n_items, n_keys, sb.matched);
    if (sb.errors == 0 && sb.pending_ct.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- aes128_block_encrypt.f -----
+incdir+rtl/core
rtl/core/aes_pkg.sv
rtl/core/aes128_block_encrypt.sv
rtl/core/aes_checker.sv
dv/aes128_block_encrypt_test.sv
